// File: design/ldk_pkg.sv
package ldk_pkg;

  localparam int COUNT_BITS_DEF = 8;
  localparam int REG_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CODE_W         = 3;

  typedef enum logic [CODE_W-1:0] {
    KEY_NONE   = 3'd0,
    KEY_TIMER  = 3'd1,
    KEY_MODE   = 3'd2,
    KEY_SWITCH = 3'd3,
    KEY_POWER  = 3'd4
  } key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASE_LEVEL = 3'd0,
    CFG_TIMER_LEVEL   = 3'd1,
    CFG_MODE_LEVEL    = 3'd2,
    CFG_SWITCH_LEVEL  = 3'd3,
    CFG_POWER_LEVEL   = 3'd4,
    CFG_DEBOUNCE      = 3'd5,
    CFG_TICKS_PER_SEC = 3'd6,
    CFG_LONG_SECONDS  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] release_level;
    logic [REG_W-1:0] timer_key_level;
    logic [REG_W-1:0] mode_key_level;
    logic [REG_W-1:0] switch_key_level;
    logic [REG_W-1:0] power_key_level;
    logic [REG_W-1:0] debounce_ticks;
    logic [REG_W-1:0] ticks_per_second;
    logic [REG_W-1:0] long_press_seconds;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    release_level:      8'd200,
    timer_key_level:    8'd185,
    mode_key_level:     8'd160,
    switch_key_level:   8'd120,
    power_key_level:    8'd10,
    debounce_ticks:     8'd5,
    ticks_per_second:   8'd100,
    long_press_seconds: 8'd3
  };

  typedef struct packed {
    logic             func;
    logic             sample_ready;
    logic [REG_W-1:0] ladder_sample;
    logic             pin_a;
    logic             pin_b;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] short_code;
    logic [CODE_W-1:0] long_code;
    logic              step_cw;
    logic              step_ccw;
  } out_word_t;

endpackage

// File: design/ldk_if.sv
interface ldk_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       sample_ready;
  logic [7:0] ladder_sample;
  logic       pin_a;
  logic       pin_b;

  modport source (output valid, func, sample_ready, ladder_sample, pin_a, pin_b,
                  input ready);
  modport sink   (input valid, func, sample_ready, ladder_sample, pin_a, pin_b,
                  output ready);
endinterface

interface ldk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] short_code;
  logic [2:0] long_code;
  logic       step_cw;
  logic       step_ccw;

  modport source (output valid, short_code, long_code, step_cw, step_ccw,
                  input ready);
  modport sink   (input valid, short_code, long_code, step_cw, step_ccw,
                  output ready);
endinterface

// File: design/ladder_key_press_and_knob_decoder.sv
// Path: an accepted input word goes into the input register, then through the
//   decode/count logic into the result register, which holds while stalled.
// Throughput: 1 word per cycle while the result register can advance.
// Reset: synchronous, active low; clears both pipeline valids, key and
//   encoder state, and loads the configuration registers with their defaults.
module ladder_key_press_and_knob_decoder #(
  parameter int COUNT_BITS = ldk_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ldk_in_if.sink                        in_ch,
  ldk_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ldk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldk_pkg::REG_W-1:0]     cfg_wdata
);
  import ldk_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word_r;
  logic      in_v_r;
  out_word_t out_word_r, out_word_nxt;
  logic      out_v_r;

  logic      advance;   // result register free to load
  logic      fire;      // input word moves into the result stage
  logic      key_go;
  logic      enc_go;
  logic [CODE_W-1:0] key_short, key_long;
  logic      enc_cw, enc_ccw;

  ldk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Output register frees up when empty or taken this cycle.
  assign advance     = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;
  assign key_go      = fire && !in_word_r.func;
  assign enc_go      = fire && in_word_r.func;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r.func          <= in_ch.func;
      in_word_r.sample_ready  <= in_ch.sample_ready;
      in_word_r.ladder_sample <= in_ch.ladder_sample;
      in_word_r.pin_a         <= in_ch.pin_a;
      in_word_r.pin_b         <= in_ch.pin_b;
    end
  end

  ldk_key_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_key (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (key_go),
    .cfg        (cfg),
    .word       (in_word_r),
    .short_code (key_short),
    .long_code  (key_long)
  );

  ldk_enc_unit u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (enc_go),
    .pin_a    (in_word_r.pin_a),
    .pin_b    (in_word_r.pin_b),
    .step_cw  (enc_cw),
    .step_ccw (enc_ccw)
  );

  // Key word carries codes only, encoder word carries steps only.
  always_comb begin
    out_word_nxt            = '0;
    if (in_word_r.func) begin
      out_word_nxt.step_cw  = enc_cw;
      out_word_nxt.step_ccw = enc_ccw;
    end else begin
      out_word_nxt.short_code = key_short;
      out_word_nxt.long_code  = key_long;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.short_code = out_word_r.short_code;
  assign out_ch.long_code  = out_word_r.long_code;
  assign out_ch.step_cw    = out_word_r.step_cw;
  assign out_ch.step_ccw   = out_word_r.step_ccw;
endmodule

// File: design/ldk_cfg_regs.sv
module ldk_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ldk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldk_pkg::REG_W-1:0]     cfg_wdata,
  output ldk_pkg::cfg_t                 cfg
);
  import ldk_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RELEASE_LEVEL: cfg_r.release_level      <= cfg_wdata;
        CFG_TIMER_LEVEL:   cfg_r.timer_key_level    <= cfg_wdata;
        CFG_MODE_LEVEL:    cfg_r.mode_key_level     <= cfg_wdata;
        CFG_SWITCH_LEVEL:  cfg_r.switch_key_level   <= cfg_wdata;
        CFG_POWER_LEVEL:   cfg_r.power_key_level    <= cfg_wdata;
        CFG_DEBOUNCE:      cfg_r.debounce_ticks     <= cfg_wdata;
        CFG_TICKS_PER_SEC: cfg_r.ticks_per_second   <= cfg_wdata;
        CFG_LONG_SECONDS:  cfg_r.long_press_seconds <= cfg_wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

// File: design/ldk_key_unit.sv
module ldk_key_unit #(
  parameter int COUNT_BITS = ldk_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  ldk_pkg::cfg_t              cfg,
  input  ldk_pkg::in_word_t          word,
  output logic [ldk_pkg::CODE_W-1:0] short_code,
  output logic [ldk_pkg::CODE_W-1:0] long_code
);
  import ldk_pkg::*;

  // wide enough for debounce_ticks + 1 and for the counter itself
  localparam int WIDE = (COUNT_BITS > REG_W + 1) ? COUNT_BITS : REG_W + 1;

  key_t                  decoded_r, decoded_nxt;
  key_t                  held_r, held_nxt;
  logic                  active_r, active_nxt;
  logic                  long_r, long_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [COUNT_BITS-1:0] sec_r, sec_nxt;

  logic [COUNT_BITS-1:0] db_m, tps_m, lps_m;
  logic                  past_debounce;

  assign db_m  = COUNT_BITS'(cfg.debounce_ticks);
  assign tps_m = COUNT_BITS'(cfg.ticks_per_second);
  assign lps_m = COUNT_BITS'(cfg.long_press_seconds);
  assign past_debounce = WIDE'(tick_r) >= (WIDE'(cfg.debounce_ticks) + WIDE'(1));

  always_comb begin
    decoded_nxt = decoded_r;
    held_nxt    = held_r;
    active_nxt  = active_r;
    long_nxt    = long_r;
    tick_nxt    = tick_r;
    sec_nxt     = sec_r;
    short_code  = KEY_NONE;
    long_code   = KEY_NONE;

    // threshold decode, dead band keeps the last key
    priority if (!word.sample_ready || word.ladder_sample >= cfg.release_level) begin
      decoded_nxt = KEY_NONE;
    end else if (word.ladder_sample > cfg.timer_key_level) begin
      decoded_nxt = KEY_TIMER;
    end else if (word.ladder_sample > cfg.mode_key_level) begin
      decoded_nxt = KEY_MODE;
    end else if (word.ladder_sample > cfg.switch_key_level) begin
      decoded_nxt = KEY_SWITCH;
    end else if (word.ladder_sample < cfg.power_key_level) begin
      decoded_nxt = KEY_POWER;
    end else begin
      decoded_nxt = decoded_r;
    end

    if (held_r != decoded_nxt) begin
      if (decoded_nxt == KEY_NONE) begin
        active_nxt = 1'b0;
        if (held_r == KEY_POWER) begin
          if (!long_r && (sec_r != '0 || past_debounce)) begin
            short_code = KEY_POWER;
          end else if (long_r) begin
            long_nxt = 1'b0;
          end
        end
      end else begin
        active_nxt = 1'b1;
        tick_nxt   = '0;
        sec_nxt    = '0;
      end
      held_nxt = decoded_nxt;
    end

    if (active_nxt) begin
      if (tick_nxt == db_m) begin
        if (held_nxt != KEY_POWER) begin
          active_nxt = 1'b0;
          short_code = held_nxt;
        end
      end else if (tick_nxt == tps_m) begin
        sec_nxt = sec_nxt + COUNT_BITS'(1);
        if (sec_nxt == lps_m) begin
          long_nxt   = 1'b1;
          sec_nxt    = '0;
          active_nxt = 1'b0;
          long_code  = held_nxt;
        end else begin
          tick_nxt = '0;
        end
      end
      tick_nxt = tick_nxt + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decoded_r <= KEY_NONE;
      held_r    <= KEY_NONE;
      active_r  <= 1'b0;
      long_r    <= 1'b0;
      tick_r    <= '0;
      sec_r     <= '0;
    end else if (go) begin
      decoded_r <= decoded_nxt;
      held_r    <= held_nxt;
      active_r  <= active_nxt;
      long_r    <= long_nxt;
      tick_r    <= tick_nxt;
      sec_r     <= sec_nxt;
    end
  end
endmodule

// File: design/ldk_enc_unit.sv
module ldk_enc_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic pin_a,
  input  logic pin_b,
  output logic step_cw,
  output logic step_ccw
);
  logic last_a_r, last_a_nxt;
  logic last_b_r, last_b_nxt;

  // B edge is checked first, then A against the updated B
  always_comb begin
    last_a_nxt = last_a_r;
    last_b_nxt = last_b_r;
    step_cw    = 1'b0;
    step_ccw   = 1'b0;
    if (last_b_r != pin_b) begin
      last_b_nxt = pin_b;
      step_cw    = (pin_b == last_a_r);
    end
    if (last_a_r != pin_a) begin
      last_a_nxt = pin_a;
      step_ccw   = (pin_a == last_b_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r <= 1'b0;
      last_b_r <= 1'b0;
    end else if (go) begin
      last_a_r <= last_a_nxt;
      last_b_r <= last_b_nxt;
    end
  end
endmodule

// File: design/ldk_checker.sv
module ldk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] short_code,
  input logic [2:0] long_code,
  input logic       step_cw,
  input logic       step_ccw
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_one_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (short_code == 3'd0 || long_code == 3'd0))
    else $error("short and long press in one word");

  a_step_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (step_cw || step_ccw) |-> (short_code == 3'd0 && long_code == 3'd0))
    else $error("encoder step together with a key code");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (short_code <= 3'd4 && long_code <= 3'd4))
    else $error("key code out of range");

endmodule

bind ladder_key_press_and_knob_decoder ldk_checker u_ldk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .short_code (out_ch.short_code),
  .long_code  (out_ch.long_code),
  .step_cw    (out_ch.step_cw),
  .step_ccw   (out_ch.step_ccw)
);

// File: verif/ladder_key_press_and_knob_decoder_tb.sv
module ladder_key_press_and_knob_decoder_tb;
  import ldk_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;        // pipeline is two words deep
  localparam int HOLD_CYCLES   = 200;      // long output hold-off
  localparam int NUM_REGS      = 8;
  localparam int RANDOM_WORDS  = 150;
  localparam int TIMEOUT_UNITS = 20 * 500_000;

  // func field of an input word
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_KNOB = 1'b1;

  // ladder class for samples that fall between the key bands
  localparam int LADDER_DEAD = 8;

  // receiver ready patterns
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  ldk_in_if  in_ch();
  ldk_out_if out_ch();

  ladder_key_press_and_knob_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Keypad / knob predictor: own copy of the registers and the key state.
  // ---------------------------------------------------------------------------
  cfg_t                       m_cfg;
  key_t                       seen_key;   // last decoded key (dead band keeps it)
  key_t                       held_key;
  logic                       press_on;
  logic                       long_hit;   // long press already reported
  logic [COUNT_BITS_DEF-1:0]  tick_cnt;
  logic [COUNT_BITS_DEF-1:0]  sec_cnt;
  logic                       a_level;
  logic                       b_level;

  out_word_t pending_codes[$];            // expected result words, oldest first
  int        mismatches;
  int        words_sent;

  // sender burst shaping
  bit gaps_on;
  int burst_left;

  // receiver control, written only by the stimulus process
  sink_mode_t sink_mode;
  bit         hold_toggle;

  // knob pin levels last driven
  logic enc_a;
  logic enc_b;

  function automatic void model_reset();
    m_cfg    = CFG_RESET;
    seen_key = KEY_NONE;
    held_key = KEY_NONE;
    press_on = 1'b0;
    long_hit = 1'b0;
    tick_cnt = '0;
    sec_cnt  = '0;
    a_level  = 1'b0;
    b_level  = 1'b0;
  endfunction

  // Threshold ladder, tested in fixed order whatever the levels.
  function automatic int ladder_class(logic rdy, logic [REG_W-1:0] s);
    if (!rdy || s >= m_cfg.release_level) return KEY_NONE;
    if (s > m_cfg.timer_key_level)        return KEY_TIMER;
    if (s > m_cfg.mode_key_level)         return KEY_MODE;
    if (s > m_cfg.switch_key_level)       return KEY_SWITCH;
    if (s < m_cfg.power_key_level)        return KEY_POWER;
    return LADDER_DEAD;
  endfunction

  function automatic out_word_t model_word(in_word_t w);
    out_word_t r;
    int        cls;
    r = '0;
    if (w.func == FUNC_KEY) begin
      cls = ladder_class(w.sample_ready, w.ladder_sample);
      if (cls != LADDER_DEAD) seen_key = key_t'(cls);
      if (held_key != seen_key) begin
        if (seen_key == KEY_NONE) begin
          press_on = 1'b0;
          // power release: short press once past debounce, unless the long press already fired
          if (held_key == KEY_POWER) begin
            if (!long_hit && (sec_cnt != 0 ||
                {1'b0, tick_cnt} >= {1'b0, m_cfg.debounce_ticks} + 9'd1)) begin
              r.short_code = KEY_POWER;
            end else if (long_hit) begin
              long_hit = 1'b0;
            end
          end
        end else begin
          // any new key, release or not, restarts the counters
          press_on = 1'b1;
          tick_cnt = '0;
          sec_cnt  = '0;
        end
        held_key = seen_key;
      end
      if (press_on) begin
        if (tick_cnt == m_cfg.debounce_ticks) begin
          if (held_key != KEY_POWER) begin
            press_on     = 1'b0;
            r.short_code = held_key;
          end
        end else if (tick_cnt == m_cfg.ticks_per_second) begin
          sec_cnt = sec_cnt + 1'b1;
          if (sec_cnt == m_cfg.long_press_seconds) begin
            long_hit    = 1'b1;
            sec_cnt     = '0;
            press_on    = 1'b0;
            r.long_code = held_key;
          end else begin
            tick_cnt = '0;
          end
        end
        tick_cnt = tick_cnt + 1'b1;
      end
    end else begin
      if (b_level != w.pin_b) begin
        b_level = w.pin_b;
        if (b_level == a_level) r.step_cw = 1'b1;
      end
      if (a_level != w.pin_a) begin
        a_level = w.pin_a;
        if (a_level == b_level) r.step_ccw = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected result word: short %0d long %0d cw %0d ccw %0d",
                 $time, out_ch.short_code, out_ch.long_code, out_ch.step_cw,
                 out_ch.step_ccw);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        if (out_ch.short_code !== want.short_code) begin
          $display("%0t: short_code expected %0d, got %0d", $time,
                   want.short_code, out_ch.short_code);
          mismatches++;
        end
        if (out_ch.long_code !== want.long_code) begin
          $display("%0t: long_code expected %0d, got %0d", $time,
                   want.long_code, out_ch.long_code);
          mismatches++;
        end
        if (out_ch.step_cw !== want.step_cw) begin
          $display("%0t: step_cw expected %0d, got %0d", $time,
                   want.step_cw, out_ch.step_cw);
          mismatches++;
        end
        if (out_ch.step_ccw !== want.step_ccw) begin
          $display("%0t: step_ccw expected %0d, got %0d", $time,
                   want.step_ccw, out_ch.step_ccw);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern per phase; a flip of hold_toggle starts a long
  // hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    bit hold_seen;
    int hold_left;
    int sink_phase;
    hold_seen    = 1'b0;
    hold_left    = 0;
    sink_phase   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      sink_phase++;
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:     out_ch.ready <= ((sink_phase % 7) >= 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word builders and sender
  // ---------------------------------------------------------------------------
  function automatic in_word_t key_word(logic rdy, logic [REG_W-1:0] s);
    in_word_t w;
    w.func          = FUNC_KEY;
    w.sample_ready  = rdy;
    w.ladder_sample = s;
    w.pin_a         = $urandom_range(0, 1);   // ignored on a key tick
    w.pin_b         = $urandom_range(0, 1);
    return w;
  endfunction

  function automatic in_word_t knob_word(logic a, logic b);
    in_word_t w;
    w.func          = FUNC_KNOB;
    w.sample_ready  = $urandom_range(0, 1);   // ignored on a knob tick
    w.ladder_sample = $urandom_range(0, 255);
    w.pin_a         = a;
    w.pin_b         = b;
    enc_a           = a;
    enc_b           = b;
    return w;
  endfunction

  // Find a sample that decodes to cls under the current levels.
  function automatic bit pick_sample(int cls, output logic [REG_W-1:0] s);
    int lo;
    int hi;
    lo = 0;
    hi = 255;
    case (cls)
      KEY_NONE:   begin lo = m_cfg.release_level;        hi = 255; end
      KEY_TIMER:  begin lo = m_cfg.timer_key_level + 1;  hi = m_cfg.release_level - 1; end
      KEY_MODE:   begin lo = m_cfg.mode_key_level + 1;   hi = m_cfg.timer_key_level; end
      KEY_SWITCH: begin lo = m_cfg.switch_key_level + 1; hi = m_cfg.mode_key_level; end
      KEY_POWER:  begin lo = 0;                          hi = m_cfg.power_key_level - 1; end
      default:    begin lo = 0;                          hi = 255; end
    endcase
    for (int n = 0; n < 32; n++) begin
      if (n < 12 && lo <= hi && lo >= 0 && hi <= 255) s = $urandom_range(hi, lo);
      else s = $urandom_range(0, 255);
      if (ladder_class(1'b1, s) == cls) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drive one word and wait for it to be taken; bursts of random length with
  // random gaps when gaps_on is set.
  task automatic send_word(in_word_t w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.func          <= w.func;
    in_ch.sample_ready  <= w.sample_ready;
    in_ch.ladder_sample <= w.ladder_sample;
    in_ch.pin_a         <= w.pin_a;
    in_ch.pin_b         <= w.pin_b;
    do @(posedge clk); while (!in_ch.ready);
    pending_codes.push_back(model_word(w));
    words_sent++;
  endtask

  // Stop offering and wait until every expected result is back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back, only with the block idle.
  task automatic apply_config(cfg_t c);
    logic [REG_W-1:0] v;
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) begin
      case (cfg_idx_t'(i))
        CFG_RELEASE_LEVEL: v = c.release_level;
        CFG_TIMER_LEVEL:   v = c.timer_key_level;
        CFG_MODE_LEVEL:    v = c.mode_key_level;
        CFG_SWITCH_LEVEL:  v = c.switch_key_level;
        CFG_POWER_LEVEL:   v = c.power_key_level;
        CFG_DEBOUNCE:      v = c.debounce_ticks;
        CFG_TICKS_PER_SEC: v = c.ticks_per_second;
        default:           v = c.long_press_seconds;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_cfg = c;
  endtask

  // Quadrature steps from the last driven pin levels, mostly one pin at a time.
  task automatic turn_knob(int steps);
    logic a;
    logic b;
    for (int n = 0; n < steps; n++) begin
      a = enc_a;
      b = enc_b;
      case ($urandom_range(0, 9))
        0:       begin a = ~a; b = ~b; end   // skipped state
        1, 2, 3: a = ~a;
        4:       ;                           // no movement
        default: b = ~b;
      endcase
      send_word(knob_word(a, b));
    end
  endtask

  // Hold one key for a number of key ticks with knob and dead-band noise,
  // then optionally release it.
  task automatic press_key(key_t k, int hold, bit let_go);
    logic [REG_W-1:0] s;
    logic [REG_W-1:0] t;
    if (!pick_sample(k, s)) return;        // key unreachable under these levels
    for (int n = 0; n < hold; n++) begin
      if ($urandom_range(0, 9) == 0) turn_knob(1);
      if (n > 0 && $urandom_range(0, 14) == 0 && pick_sample(LADDER_DEAD, t)) begin
        send_word(key_word(1'b1, t));
      end else begin
        if (pick_sample(k, t)) s = t;
        send_word(key_word(1'b1, s));
      end
    end
    if (let_go) begin
      if ($urandom_range(0, 1) == 0 || !pick_sample(KEY_NONE, t))
        send_word(key_word(1'b0, $urandom_range(0, 255)));
      else
        send_word(key_word(1'b1, t));
    end
  endtask

  task automatic random_press();
    key_t k;
    int   hold;
    k = key_t'($urandom_range(KEY_TIMER, KEY_POWER));
    case ($urandom_range(0, 3))
      0:       hold = $urandom_range(1, m_cfg.debounce_ticks + 2);
      1:       hold = m_cfg.ticks_per_second * m_cfg.long_press_seconds
                      + $urandom_range(0, 4);
      default: hold = $urandom_range(1, 12);
    endcase
    if (hold > 80) hold = $urandom_range(1, 80);
    press_key(k, hold, $urandom_range(0, 5) != 0);   // else direct key change
  endtask

  // Mostly well-formed presses, the rest knob turns and raw noise.
  task automatic run_mix(int n_words);
    int               stop;
    logic [REG_W-1:0] s;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: random_press();
        6, 7:             turn_knob($urandom_range(1, 6));
        8:                send_word(key_word($urandom_range(0, 1), $urandom_range(0, 255)));
        default: begin
          if (pick_sample(LADDER_DEAD, s)) send_word(key_word(1'b1, s));
          else send_word(key_word(1'b1, $urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  function automatic cfg_t random_levels();
    cfg_t c;
    c.release_level    = $urandom_range(150, 255);
    c.timer_key_level  = $urandom_range(100, c.release_level);
    c.mode_key_level   = $urandom_range(60, c.timer_key_level);
    c.switch_key_level = $urandom_range(20, c.mode_key_level);
    c.power_key_level  = $urandom_range(1, c.switch_key_level);
    if ($urandom_range(0, 4) == 0) begin
      // scrambled levels: bands overlap or vanish
      c.timer_key_level  = $urandom_range(0, 255);
      c.mode_key_level   = $urandom_range(0, 255);
      c.switch_key_level = $urandom_range(0, 255);
      c.power_key_level  = $urandom_range(0, 255);
    end
    c.debounce_ticks     = $urandom_range(1, 8);
    c.ticks_per_second   = $urandom_range(2, 12);
    c.long_press_seconds = $urandom_range(1, 3);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset levels: scale ends, each key, dead band, direct changes, a power
  // release too early to count, and both knob directions plus a skipped state.
  task automatic test_directed();
    sink_mode <= SINK_OPEN;
    gaps_on = 1'b0;
    send_word(key_word(1'b0, 8'h00));        // conversion not finished
    send_word(key_word(1'b1, 8'hFF));        // top of scale
    send_word(key_word(1'b1, 8'd200));       // exactly at release level
    repeat (6) send_word(key_word(1'b1, 8'd199));   // timer, reported on 6th
    send_word(key_word(1'b1, 8'd60));        // dead band keeps timer
    send_word(key_word(1'b1, 8'd161));       // mode, no release between
    send_word(key_word(1'b1, 8'd121));       // switch
    send_word(key_word(1'b1, 8'd0));         // power
    send_word(key_word(1'b1, 8'd120));       // dead band keeps power
    send_word(key_word(1'b1, 8'd255));       // release before debounce
    send_word(knob_word(1'b0, 1'b1));
    send_word(knob_word(1'b1, 1'b1));
    send_word(knob_word(1'b1, 1'b0));
    send_word(knob_word(1'b0, 1'b0));
    send_word(knob_word(1'b1, 1'b0));
    send_word(knob_word(1'b1, 1'b1));
    send_word(knob_word(1'b0, 1'b1));
    send_word(knob_word(1'b0, 1'b0));
    send_word(knob_word(1'b1, 1'b1));        // both pins at once
  endtask

  // Power short and long presses, latch kept across a direct change, slow
  // debounce, and one long press at real-time tick rates.
  task automatic test_long_presses();
    cfg_t c;
    c = CFG_RESET;
    c.debounce_ticks     = 2;
    c.ticks_per_second   = 3;
    c.long_press_seconds = 2;
    apply_config(c);
    sink_mode <= SINK_RANDOM;
    gaps_on = 1'b1;
    press_key(KEY_POWER, 10, 1'b1);          // long, release clears latch
    press_key(KEY_POWER, 4, 1'b1);           // short on release
    press_key(KEY_POWER, 1, 1'b1);           // bounce only
    press_key(KEY_POWER, 10, 1'b0);          // long ...
    press_key(KEY_MODE, 3, 1'b0);            // ... latch survives key change
    press_key(KEY_POWER, 4, 1'b1);           // release eats the latch
    press_key(KEY_TIMER, 5, 1'b1);
    c.debounce_ticks = 9;                    // debounce longer than a second
    apply_config(c);
    press_key(KEY_SWITCH, 10, 1'b1);
    press_key(KEY_TIMER, 8, 1'b1);
    apply_config(CFG_RESET);
    sink_mode <= SINK_PERIODIC;
    press_key(KEY_POWER, 310, 1'b1);
    press_key(KEY_POWER, 150, 1'b1);
  endtask

  // Register extremes and overlapping or empty bands.
  task automatic test_threshold_corners();
    cfg_t c;
    gaps_on = 1'b1;
    c = '{release_level: 8'd255, timer_key_level: 8'd254, mode_key_level: 8'd128,
          switch_key_level: 8'd1, power_key_level: 8'd255, debounce_ticks: 8'd1,
          ticks_per_second: 8'd2, long_press_seconds: 8'd1};
    apply_config(c);
    sink_mode <= SINK_OPEN;
    run_mix(80);
    // everything decodes as no key
    c = '{release_level: 8'd0, timer_key_level: 8'd255, mode_key_level: 8'd255,
          switch_key_level: 8'd255, power_key_level: 8'd0, debounce_ticks: 8'd254,
          ticks_per_second: 8'd255, long_press_seconds: 8'd255};
    apply_config(c);
    sink_mode <= SINK_RANDOM;
    run_mix(60);
    c = '{release_level: 8'd255, timer_key_level: 8'd0, mode_key_level: 8'd0,
          switch_key_level: 8'd0, power_key_level: 8'd255, debounce_ticks: 8'd1,
          ticks_per_second: 8'd255, long_press_seconds: 8'd1};
    apply_config(c);
    sink_mode <= SINK_PERIODIC;
    run_mix(80);
  endtask

  // Output held off while the sender keeps offering, so the input stalls;
  // then the sender drains before going on.
  task automatic test_backpressure();
    apply_config(random_levels());
    sink_mode <= SINK_OPEN;
    gaps_on = 1'b0;
    hold_toggle <= ~hold_toggle;
    run_mix(40);
    wait_idle();
    run_mix(40);
  endtask

  task automatic test_random_mix();
    int first;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      apply_config(random_levels());
      sink_mode <= sink_mode_t'($urandom_range(0, 2));
      gaps_on = $urandom_range(0, 1);
      if ($urandom_range(0, 5) == 0) hold_toggle <= ~hold_toggle;
      run_mix($urandom_range(60, 150));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_RELEASE_LEVEL;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_KEY;
    in_ch.sample_ready  <= 1'b0;
    in_ch.ladder_sample <= '0;
    in_ch.pin_a         <= 1'b0;
    in_ch.pin_b         <= 1'b0;
    sink_mode           <= SINK_OPEN;
    hold_toggle         <= 1'b0;
    enc_a       = 1'b0;
    enc_b       = 1'b0;
    mismatches  = 0;
    words_sent  = 0;
    burst_left  = 0;
    gaps_on     = 1'b0;
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_long_presses();
    test_threshold_corners();
    test_backpressure();
    test_random_mix();

    wait_idle();
    if (mismatches == 0) begin
      $display("ladder_key_press_and_knob_decoder_tb: done, clean");
    end else begin
      $display("ladder_key_press_and_knob_decoder_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("ladder_key_press_and_knob_decoder_tb: done, errors");
    $finish;
  end

endmodule

// File: ladder_key_press_and_knob_decoder.f
design/ldk_pkg.sv
design/ldk_if.sv
design/ldk_cfg_regs.sv
design/ldk_key_unit.sv
design/ldk_enc_unit.sv
design/ladder_key_press_and_knob_decoder.sv
design/ldk_checker.sv
verif/ladder_key_press_and_knob_decoder_tb.sv
